@@ rtl/core/qei_pkg.sv @@
// Shared types and constants for the quadratic easing interpolator.
`timescale 1ns / 1ps

package qei_pkg;

  typedef enum logic [1:0] {
    CURVE_EASE_IN     = 2'd0,
    CURVE_EASE_OUT    = 2'd1,
    CURVE_EASE_IN_OUT = 2'd2,
    CURVE_LINEAR      = 2'd3
  } curve_mode_t;

  // Register map: index = paddr[5:3], 64-bit registers at 8-byte spacing
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned PDATA_W   = 64;
  localparam logic [2:0] REG_CURVE_MODE  = 3'd0;
  localparam logic [2:0] REG_START_LEVEL = 3'd1;
  localparam logic [2:0] REG_END_LEVEL   = 3'd2;
  localparam logic [2:0] REG_BEGIN_TICK  = 3'd3;
  localparam logic [2:0] REG_END_TICK    = 3'd4;

  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned WEIGHT_W   = 14;
  localparam int unsigned DIV_STEPS  = 7;

  localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]    PCT_HALF    = 7'd50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 14'd10000;
  localparam logic signed [31:0]  ROUND_HALF  = 32'sd5000;

  // floor(x/10000) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2^31
  localparam logic [30:0] RECIP_M     = 31'd1759218605;
  localparam int unsigned RECIP_SHIFT = 44;
  localparam int unsigned QUOT_W      = 18;
  // bias makes the rounded numerator non-negative: 65536 * 10000
  localparam logic signed [31:0] FLOOR_BIAS = 32'sd655360000;
  localparam logic signed [18:0] QUOT_BIAS  = 19'sd65536;

  typedef struct packed {
    logic load;      // latch sample on input request
    logic classify;  // compare against segment ends
    logic prep;      // set up percent divider
    logic div_step;  // one restoring quotient bit
    logic weight;    // square of progress term
    logic scale;     // diff * weight + rounding
    logic recip;     // divide by 10000 via reciprocal
    logic emit;      // write result register
  } cmd_t;

  typedef struct packed {
    logic pre_begin;
    logic after;
    logic span_zero;
  } status_t;

endpackage

@@ rtl/core/qei_cfg_regs.sv @@
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module qei_cfg_regs #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qei_pkg::PADDR_W-1:0]   paddr,
  input  logic [qei_pkg::PDATA_W-1:0]   pwdata,
  output logic [qei_pkg::PDATA_W-1:0]   prdata,
  output logic [1:0]                    curve_mode,
  output logic [qei_pkg::LEVEL_W-1:0]   start_level,
  output logic [qei_pkg::LEVEL_W-1:0]   end_level,
  output logic [TIME_WIDTH-1:0]         begin_tick,
  output logic [TIME_WIDTH-1:0]         end_tick,
  output logic                          cfg_write
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[qei_pkg::PADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    case (reg_idx)
      qei_pkg::REG_CURVE_MODE,
      qei_pkg::REG_START_LEVEL,
      qei_pkg::REG_END_LEVEL,
      qei_pkg::REG_BEGIN_TICK,
      qei_pkg::REG_END_TICK: cfg_write = wr_en;
      default:               cfg_write = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= '0;
      start_level <= '0;
      end_level   <= '0;
      begin_tick  <= '0;
      end_tick    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        qei_pkg::REG_CURVE_MODE:  curve_mode  <= pwdata[1:0];
        qei_pkg::REG_START_LEVEL: start_level <= pwdata[qei_pkg::LEVEL_W-1:0];
        qei_pkg::REG_END_LEVEL:   end_level   <= pwdata[qei_pkg::LEVEL_W-1:0];
        qei_pkg::REG_BEGIN_TICK:  begin_tick  <= pwdata[TIME_WIDTH-1:0];
        qei_pkg::REG_END_TICK:    end_tick    <= pwdata[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      qei_pkg::REG_CURVE_MODE:  prdata[1:0] = curve_mode;
      qei_pkg::REG_START_LEVEL: prdata[qei_pkg::LEVEL_W-1:0] = start_level;
      qei_pkg::REG_END_LEVEL:   prdata[qei_pkg::LEVEL_W-1:0] = end_level;
      qei_pkg::REG_BEGIN_TICK:  prdata[TIME_WIDTH-1:0] = begin_tick;
      qei_pkg::REG_END_TICK:    prdata[TIME_WIDTH-1:0] = end_tick;
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/qei_ctrl.sv @@
// Sequencer for one sample: classify, then divide, weight, scale and reciprocal as the case needs, then emit.
`timescale 1ns / 1ps

module qei_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  qei_pkg::status_t status,
  output qei_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_PREP,
    ST_DIVIDE,
    ST_WEIGHT,
    ST_SCALE,
    ST_RECIP,
    ST_EMIT
  } state_t;

  state_t     state;
  logic [2:0] step_cnt;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:     cmd.load     = s_tvalid;
      ST_CLASSIFY: cmd.classify = 1'b1;
      ST_PREP:     cmd.prep     = 1'b1;
      ST_DIVIDE:   cmd.div_step = 1'b1;
      ST_WEIGHT:   cmd.weight   = 1'b1;
      ST_SCALE:    cmd.scale    = 1'b1;
      ST_RECIP:    cmd.recip    = 1'b1;
      ST_EMIT:     cmd.emit     = out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_CLASSIFY;
        end
        ST_CLASSIFY: begin
          if (status.pre_begin || status.after) begin
            state <= ST_EMIT;
          end else if (status.span_zero) begin
            state <= ST_WEIGHT;
          end else begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_cnt <= '0;
          state    <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          step_cnt <= step_cnt + 3'd1;
          if (step_cnt == 3'(qei_pkg::DIV_STEPS - 1)) state <= ST_WEIGHT;
        end
        ST_WEIGHT: state <= ST_SCALE;
        ST_SCALE:  state <= ST_RECIP;
        ST_RECIP:  state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/qei_datapath.sv @@
// Classification, percent divider, easing weight, scaling, reciprocal division and result register.
`timescale 1ns / 1ps

module qei_datapath #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  qei_pkg::cmd_t                       cmd,
  output qei_pkg::status_t                    status,
  input  logic [TIME_WIDTH-1:0]               sample_time,
  input  logic [1:0]                          curve_mode,
  input  logic [qei_pkg::LEVEL_W-1:0]         start_level,
  input  logic [qei_pkg::LEVEL_W-1:0]         end_level,
  input  logic [TIME_WIDTH-1:0]               begin_tick,
  input  logic [TIME_WIDTH-1:0]               end_tick,
  input  logic                                cfg_write,
  output logic [qei_pkg::OUT_DATA_W-1:0]      result
);

  localparam int unsigned DW = TIME_WIDTH + qei_pkg::PCT_W;

  logic [TIME_WIDTH-1:0]         t_reg;
  logic [TIME_WIDTH-1:0]         d_reg;
  logic [TIME_WIDTH-1:0]         span;
  logic                          before_r;
  logic                          after_r;
  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 dvs;
  logic [qei_pkg::PCT_W-1:0]     pct;
  logic [qei_pkg::WEIGHT_W-1:0]  sq;
  logic signed [31:0]            num;
  logic [qei_pkg::QUOT_W-1:0]    quot;
  logic                          finished_flag;

  logic                          ge;
  logic [DW-1:0]                 d_ext;
  logic                          pct_low;
  logic [qei_pkg::PCT_W-1:0]     sq_base;
  logic [qei_pkg::WEIGHT_W:0]    sq2;
  logic [qei_pkg::WEIGHT_W-1:0]  weight;
  logic signed [16:0]            diff;
  logic signed [31:0]            scaled;
  logic signed [31:0]            biased;
  logic [61:0]                   recip_prod;
  logic signed [18:0]            level_sum;

  assign status.pre_begin = (t_reg < begin_tick);
  assign status.after     = (t_reg > end_tick);
  assign status.span_zero = (begin_tick == end_tick);

  assign d_ext = {{qei_pkg::PCT_W{1'b0}}, d_reg};
  assign ge    = (rem >= dvs);

  assign pct_low = (pct < qei_pkg::PCT_HALF);
  assign sq_base = (curve_mode == qei_pkg::CURVE_EASE_IN ||
                    (curve_mode == qei_pkg::CURVE_EASE_IN_OUT && pct_low))
                   ? pct : (qei_pkg::PCT_FULL - pct);
  assign sq2 = {sq, 1'b0};

  always_comb begin
    case (curve_mode)
      qei_pkg::CURVE_EASE_IN:  weight = sq;
      qei_pkg::CURVE_EASE_OUT: weight = qei_pkg::WEIGHT_FULL - sq;
      qei_pkg::CURVE_EASE_IN_OUT: begin
        if (pct_low) begin
          weight = sq2[qei_pkg::WEIGHT_W-1:0];
        end else begin
          weight = qei_pkg::WEIGHT_FULL - sq2[qei_pkg::WEIGHT_W-1:0];
        end
      end
      default: weight = qei_pkg::WEIGHT_W'(pct * qei_pkg::PCT_FULL);
    endcase
  end

  assign diff   = $signed({end_level[qei_pkg::LEVEL_W-1], end_level}) -
                  $signed({start_level[qei_pkg::LEVEL_W-1], start_level});
  assign scaled = diff * $signed({1'b0, weight}) + qei_pkg::ROUND_HALF;
  assign biased = num + qei_pkg::FLOOR_BIAS;
  assign recip_prod = biased[30:0] * qei_pkg::RECIP_M;
  assign level_sum  = $signed({{3{start_level[qei_pkg::LEVEL_W-1]}}, start_level}) +
                      $signed({1'b0, quot}) - qei_pkg::QUOT_BIAS;

  always_ff @(posedge clk) begin
    if (cmd.load) t_reg <= sample_time;
    if (cmd.classify) begin
      before_r <= status.pre_begin;
      after_r  <= status.after;
      d_reg    <= t_reg - begin_tick;
      span     <= end_tick - begin_tick;
      // empty segment counts as fully progressed
      if (status.span_zero) pct <= qei_pkg::PCT_FULL;
    end
    if (cmd.prep) begin
      // 100*d as shift-adds
      rem <= (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
      dvs <= {1'b0, span, 6'b0};
      pct <= '0;
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dvs;
      dvs <= dvs >> 1;
      pct <= {pct[qei_pkg::PCT_W-2:0], ge};
    end
    if (cmd.weight) sq <= qei_pkg::WEIGHT_W'(sq_base * sq_base);
    if (cmd.scale)  num <= scaled;
    if (cmd.recip)  quot <= recip_prod[61:qei_pkg::RECIP_SHIFT];
  end

  // result: {pad, segment_finished, level, level_valid}
  always_ff @(posedge clk) begin
    if (rst) begin
      finished_flag <= 1'b0;
      result        <= '0;
    end else begin
      if (cfg_write) finished_flag <= 1'b0;
      if (cmd.emit) begin
        result[qei_pkg::OUT_DATA_W-1:18] <= '0;
        if (before_r) begin
          result[0]    <= 1'b0;
          result[16:1] <= '0;
          result[17]   <= finished_flag;
        end else if (after_r) begin
          result[0]     <= 1'b1;
          result[16:1]  <= end_level;
          result[17]    <= 1'b1;
          finished_flag <= 1'b1;
        end else begin
          result[0]    <= 1'b1;
          result[16:1] <= level_sum[qei_pkg::LEVEL_W-1:0];
          result[17]   <= finished_flag;
        end
      end
    end
  end

endmodule

@@ rtl/core/quadratic_easing_interpolator.sv @@
// Quadratic easing interpolator: top level joining registers, sequencer and datapath.
// Each request on the input stream is one sample time evaluated against the configured
// segment and yields exactly one result. A sample before the segment or past its end
// goes from classification straight to the output register; one on an empty segment
// passes through weight, scale and reciprocal first; one inside the segment also
// through the restoring divider, which forms the whole-percent progress one quotient
// bit per cycle. A new request is taken in the cycle after the previous one has been
// written to the output register, which holds it until the downstream side takes it.
// The user must write registers only while no request is in progress; the block does
// not enforce this. Any write to a defined register clears the sticky finished flag.
`timescale 1ns / 1ps

module quadratic_easing_interpolator #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // sample_time
  input  logic [((TIME_WIDTH + 7) / 8) * 8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // level_valid [0], level [16:1], segment_finished [17], zero pad above
  output logic [qei_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [qei_pkg::PADDR_W-1:0]           paddr,
  input  logic [qei_pkg::PDATA_W-1:0]           pwdata,
  output logic [qei_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  logic [1:0]                  curve_mode;
  logic [qei_pkg::LEVEL_W-1:0] start_level;
  logic [qei_pkg::LEVEL_W-1:0] end_level;
  logic [TIME_WIDTH-1:0]       begin_tick;
  logic [TIME_WIDTH-1:0]       end_tick;
  logic                        cfg_write;
  qei_pkg::cmd_t               cmd;
  qei_pkg::status_t            status;

  assign pready = 1'b1;

  qei_cfg_regs #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .curve_mode  (curve_mode),
    .start_level (start_level),
    .end_level   (end_level),
    .begin_tick  (begin_tick),
    .end_tick    (end_tick),
    .cfg_write   (cfg_write)
  );

  qei_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qei_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample_time (s_tdata[TIME_WIDTH-1:0]),
    .curve_mode  (curve_mode),
    .start_level (start_level),
    .end_level   (end_level),
    .begin_tick  (begin_tick),
    .end_tick    (end_tick),
    .cfg_write   (cfg_write),
    .result      (m_tdata)
  );

endmodule
